@@ rtl/mbps_pkg.sv @@
// shared types, constants and helpers for the masked byte pattern scan core
package mbps_pkg;

  localparam int MAX_PATTERN = 128;
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int STEP_W      = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam int OK_GROUPS   = (MAX_PATTERN + 7) / 8;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int PAT_LANE_W  = 9;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_SCAN = 1'b1;

  localparam logic REG_IMAGE_BASE     = 1'b0;
  localparam logic REG_PATTERN_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_SCAN,
    KIND_SKIP
  } kind_t;

  typedef enum logic [1:0] {
    AL_IDLE,
    AL_LOAD,
    AL_SHIFT
  } align_state_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] entry_index;
    logic [7:0] value;
    logic       care;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic       care;
    logic [7:0] pat;
  } pat_lane_t;

  typedef pat_lane_t [MAX_PATTERN-1:0] pat_vec_t;
  typedef logic [MAX_PATTERN-1:0][7:0] win_vec_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    pat_lane_t        lane;
  } pat_wr_t;

  // clamp the programmed length into 1..MAX_PATTERN
  function automatic logic [LEN_W-1:0] eff_len(input logic [7:0] l);
    logic [LEN_W-1:0] r;
    if (l == 8'd0) begin
      r = LEN_W'(1);
    end else if (32'(l) > MAX_PATTERN) begin
      r = LEN_W'(MAX_PATTERN);
    end else begin
      r = LEN_W'(l);
    end
    return r;
  endfunction

endpackage

@@ rtl/masked_byte_pattern_scan_core.sv @@
// top level of the masked byte pattern scan core
// Searches a byte stream for a pattern with wildcard bytes.
// Input requests (s_t*): tuser=0 loads pattern entry entry_index with value and
// care (care 0 is a wildcard); tuser=1 delivers one image byte, tlast marks
// the final byte of the image. Loads produce no result.
// Results (m_t*): tuser is found, tdata the match address (image_base plus the
// start offset). The first match of an image gives one result with found=1;
// an image that ends without a match gives found=0 and address 0.
// Config: cfg_we/cfg_index/cfg_data write image_base (0) or pattern_length (1).
// Results: a scan byte passes the queue, the p1 stage and the output register.
// Throughput: one request per cycle while no realign runs and the output is not
// stalled; the byte window and the compare of all pattern lanes run each cycle,
// backed by a four-entry queue. A pattern_length write, and reset, start a
// realign of the pattern lanes; requests still queue but wait for its end.
// Reset clears the window, byte count, queue and output; pattern bytes are
// undefined until loaded. When m_tready is low the result holds in the output
// register, the compare pipeline then fills and the queue backs up to s_tready.
module masked_byte_pattern_scan_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // entry_index[6:0], value[14:7], care[15]
  input  logic        s_tuser,   // func
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // match_address[31:0]
  output logic        m_tuser,   // found
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mbps_pkg::*;

  logic [31:0]      image_base;
  logic [7:0]       pattern_length;
  logic [LEN_W-1:0] len;
  logic             len_write;
  logic             q_valid;
  item_t            q_item;
  logic             q_pop;
  logic             align_busy;
  pat_vec_t         ap;
  pat_wr_t          pat_wr;

  assign len_write = cfg_we && (cfg_index == REG_PATTERN_LENGTH);
  assign len       = eff_len(pattern_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_base     <= 32'd0;
      pattern_length <= 8'd1;
    end else if (cfg_we) begin
      if (cfg_index == REG_IMAGE_BASE) begin
        image_base <= cfg_data;
      end else begin
        pattern_length <= cfg_data[7:0];
      end
    end
  end

  mbps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  mbps_align u_align (
    .clk    (clk),
    .rst    (rst),
    .start  (len_write),
    .len    (len),
    .pat_wr (pat_wr),
    .ap     (ap),
    .busy   (align_busy)
  );

  mbps_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .align_busy (align_busy),
    .ap         (ap),
    .len        (len),
    .image_base (image_base),
    .pat_wr     (pat_wr),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  // nothing leaves the queue while the pattern lanes are being realigned
  a_no_pop_while_align: assert property (@(posedge clk) disable iff (rst)
    align_busy |-> !q_pop)
    else $error("queue popped during pattern realign");

  // a length write always starts a realign
  a_len_write_realign: assert property (@(posedge clk) disable iff (rst)
    len_write |=> align_busy)
    else $error("pattern length write did not start realign");

  // a no-match result carries address zero
  a_miss_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == 32'd0))
    else $error("no-match result with nonzero address");

  // only load requests write the pattern store
  a_load_only_write: assert property (@(posedge clk) disable iff (rst)
    pat_wr.we |-> (q_pop && q_item.kind == KIND_LOAD))
    else $error("pattern write without a load request");

endmodule

@@ rtl/mbps_front.sv @@
// front end: takes requests, classifies them and queues them for the back end
module mbps_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,   // entry_index[6:0], value[14:7], care[15]
  input  logic                 s_tuser,   // func
  input  logic                 s_tlast,   // last_byte
  output logic                 q_valid,
  output mbps_pkg::item_t      q_item,
  input  logic                 q_pop
);
  import mbps_pkg::*;

  item_t             fifo [QDEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [QCNT_W-1:0] count;
  item_t             in_item;
  logic              push;

  always_comb begin
    in_item.entry_index = s_tdata[6:0];
    in_item.value       = s_tdata[14:7];
    in_item.care        = s_tdata[15];
    in_item.last_byte   = 1'b0;
    if (s_tuser == FUNC_SCAN) begin
      in_item.kind      = KIND_SCAN;
      in_item.last_byte = s_tlast;
    end else if (32'(s_tdata[6:0]) < MAX_PATTERN) begin
      in_item.kind = KIND_LOAD;
    end else begin
      in_item.kind = KIND_SKIP;
    end
  end

  assign s_tready = (count != QCNT_W'(QDEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign q_item   = fifo[head];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[tail] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + QPTR_W'(1);
      end
      if (q_pop) begin
        head <= head + QPTR_W'(1);
      end
      if (push && !q_pop) begin
        count <= count + QCNT_W'(1);
      end else if (!push && q_pop) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/mbps_align.sv @@
// pattern store and length-aligned pattern lanes with a log-step realign sequencer
module mbps_align (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [mbps_pkg::LEN_W-1:0] len,
  input  mbps_pkg::pat_wr_t      pat_wr,
  output mbps_pkg::pat_vec_t     ap,
  output logic                   busy
);
  import mbps_pkg::*;

  pat_vec_t          store;
  align_state_t      state;
  align_state_t      state_next;
  logic [STEP_W-1:0] step;
  logic              do_reverse;
  logic              do_shift;
  logic [LEN_W-1:0]  k_full;
  logic [IDX_W-1:0]  shift_amt;
  logic [LEN_W-1:0]  lane_full;
  logic              lane_hit;

  // lane a of ap holds pattern entry len-1-a; lanes at or above len carry care 0
  assign k_full    = LEN_W'(MAX_PATTERN) - len;
  assign shift_amt = k_full[IDX_W-1:0];
  assign lane_full = len - LEN_W'(1) - LEN_W'(pat_wr.idx);
  assign lane_hit  = (LEN_W'(pat_wr.idx) < len);

  always_comb begin
    state_next = state;
    unique case (state)
      AL_IDLE:  state_next = start ? AL_LOAD : AL_IDLE;
      AL_LOAD:  state_next = start ? AL_LOAD : AL_SHIFT;
      AL_SHIFT: begin
        if (start) begin
          state_next = AL_LOAD;
        end else if (step == STEP_W'(IDX_W - 1)) begin
          state_next = AL_IDLE;
        end
      end
      default:  state_next = AL_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    do_reverse = 1'b0;
    do_shift   = 1'b0;
    unique case (state)
      AL_IDLE:  busy = 1'b0;
      AL_LOAD:  do_reverse = 1'b1;
      AL_SHIFT: do_shift = 1'b1;
      default:  busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AL_LOAD;
      step  <= '0;
    end else begin
      state <= state_next;
      if (do_shift) begin
        step <= step + STEP_W'(1);
      end else begin
        step <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pat_wr.we) begin
      store[pat_wr.idx] <= pat_wr.lane;
    end
  end

  always_ff @(posedge clk) begin
    if (do_reverse) begin
      for (int a = 0; a < MAX_PATTERN; a++) begin
        ap[a] <= store[MAX_PATTERN-1-a];
      end
    end else if (do_shift) begin
      // binary step of the down shift by MAX_PATTERN - len, zeros shift in
      if (shift_amt[step]) begin
        ap <= ap >> (PAT_LANE_W << step);
      end
    end else if (pat_wr.we && lane_hit) begin
      ap[lane_full[IDX_W-1:0]] <= pat_wr.lane;
    end
  end

endmodule

@@ rtl/mbps_scan.sv @@
// back end: byte window, parallel masked compare pipeline and result register
module mbps_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  mbps_pkg::item_t            q_item,
  output logic                       q_pop,
  input  logic                       align_busy,
  input  mbps_pkg::pat_vec_t         ap,
  input  logic [mbps_pkg::LEN_W-1:0] len,
  input  logic [31:0]                image_base,
  output mbps_pkg::pat_wr_t          pat_wr,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [31:0]                m_tdata,  // match_address
  output logic                       m_tuser   // found
);
  import mbps_pkg::*;

  win_vec_t                    window;
  win_vec_t                    win_shift;
  logic [31:0]                 bytes_seen;
  logic [31:0]                 seen_next;
  logic                        match_done;
  logic [OK_GROUPS*8-1:0]      ok_pad;
  logic [OK_GROUPS-1:0]        grp_ok;
  logic                        scan_pop;

  logic                        p1_valid;
  logic                        p1_last;
  logic                        p1_enough;
  logic [31:0]                 p1_offset;
  logic [OK_GROUPS-1:0]        p1_grp_ok;

  logic                        match;
  logic                        no_match_end;
  logic                        has_res;
  logic                        out_free;
  logic                        adv;

  // stage 2: decide the result of the scan byte held in p1
  assign match        = p1_valid && !match_done && p1_enough && (&p1_grp_ok);
  assign no_match_end = p1_valid && !match_done && p1_last && !match;
  assign has_res      = match || no_match_end;
  assign out_free     = !m_tvalid || m_tready;
  assign adv          = !p1_valid || !has_res || out_free;

  assign q_pop    = q_valid && !align_busy && ((q_item.kind != KIND_SCAN) || adv);
  assign scan_pop = q_pop && (q_item.kind == KIND_SCAN);

  always_comb begin
    pat_wr.we        = q_pop && (q_item.kind == KIND_LOAD);
    pat_wr.idx       = IDX_W'(q_item.entry_index);
    pat_wr.lane.care = q_item.care;
    pat_wr.lane.pat  = q_item.value;
  end

  // stage 1: shift in the new byte and compare every lane at once
  always_comb begin
    win_shift    = window << 8;
    win_shift[0] = q_item.value;
    seen_next    = (bytes_seen == 32'hFFFF_FFFF) ? bytes_seen : bytes_seen + 32'd1;
    ok_pad       = '1;
    for (int a = 0; a < MAX_PATTERN; a++) begin
      ok_pad[a] = !ap[a].care || (win_shift[a] == ap[a].pat);
    end
    for (int g = 0; g < OK_GROUPS; g++) begin
      grp_ok[g] = &ok_pad[g*8 +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      bytes_seen <= '0;
    end else if (scan_pop) begin
      if (q_item.last_byte) begin
        window     <= '0;
        bytes_seen <= '0;
      end else begin
        window     <= win_shift;
        bytes_seen <= seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_pop) begin
      p1_last   <= q_item.last_byte;
      p1_enough <= (seen_next >= 32'(len));
      p1_offset <= seen_next - 32'(len);
      p1_grp_ok <= grp_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid   <= 1'b0;
      match_done <= 1'b0;
    end else begin
      if (scan_pop) begin
        p1_valid <= 1'b1;
      end else if (adv) begin
        p1_valid <= 1'b0;
      end
      if (p1_valid && adv) begin
        match_done <= p1_last ? 1'b0 : (match_done || match);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && has_res) begin
      m_tuser <= match;
      m_tdata <= match ? (image_base + p1_offset) : 32'd0;
    end
  end

endmodule
